@@ design/nn_activation_unit_core_macros.svh @@
// ----------------------------------------------------------------------------
// nn_activation_unit_core_macros
// Assertion macros for the activation unit core.
// ----------------------------------------------------------------------------
`ifndef NN_ACTIVATION_UNIT_CORE_MACROS_SVH
`define NN_ACTIVATION_UNIT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NNACT_CHK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NNACT_CHK_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nnact_pkg.sv @@
// ----------------------------------------------------------------------------
// nnact_pkg
// Types, mode codes, fixed-point constants and the tanh table.
// ----------------------------------------------------------------------------
`default_nettype none

package nnact_pkg;

  // activation mode codes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_RELU   = 3'd1;
  localparam logic [2:0] MODE_RELU6  = 3'd2;
  localparam logic [2:0] MODE_HSIG   = 3'd3;
  localparam logic [2:0] MODE_HSWISH = 3'd4;
  localparam logic [2:0] MODE_GELU   = 3'd5;
  localparam logic [2:0] MODE_TANH   = 3'd6;
  localparam logic [2:0] MODE_UNSUP  = 3'd7;

  // fixed-point constants
  localparam logic [19:0] C1_Q24   = 20'd750193;    // 0.044715
  localparam logic [23:0] K0_Q24   = 24'd13386282;  // sqrt(2/pi)
  localparam logic [17:0] RECIP3   = 18'd174763;    // 2^19 / 3, rounded up

  // tanh table: entry k is tanh(4k/N) in Q15
  localparam int TANH_ENTRIES = 256;
  localparam int TANH_IW      = $clog2(TANH_ENTRIES);
  localparam int TANH_FB      = 18;
  localparam int TANH_PW      = TANH_FB + TANH_IW;

  typedef logic [TANH_ENTRIES:0][15:0] tanh_rom_t;

  // shift-subtract quotient, only evaluated while the table is built
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // series for e^(8k/N) in Q30, then (E-1)/(E+1) rounded to Q15
  function automatic tanh_rom_t tanh_rom_build();
    tanh_rom_t       rom;
    longint unsigned e;
    longint unsigned term;
    longint unsigned num;
    longint unsigned den;
    longint unsigned one;
    int              n;
    one = 64'd1 << 30;
    rom = '0;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      e    = one;
      term = one;
      n    = 1;
      while (n <= 256 && term != 0) begin
        term = udiv64(term * longint'(8 * k), longint'(TANH_ENTRIES * n));
        e    = e + term;
        n    = n + 1;
      end
      num    = (e - one) << 15;
      den    = e + one;
      rom[k] = 16'(udiv64(num + (den >> 1), den));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = tanh_rom_build();

  // per-sample fields carried down the pipe
  typedef struct packed {
    logic signed [15:0] x;
    logic [15:0]        m;
    logic               neg;
    logic [2:0]         mode;
    logic               last;
  } base_t;

  typedef struct packed {
    base_t              b;
    logic [55:0]        m3c;
    logic signed [16:0] simple;
  } front_t;

  typedef struct packed {
    base_t              b;
    logic [17:0]        targ;
    logic               tbig;
    logic signed [16:0] simple;
  } poly_t;

  typedef struct packed {
    base_t              b;
    logic [15:0]        t;
    logic signed [16:0] simple;
  } tanh_t;

endpackage

`default_nettype wire

@@ design/nnact_if.sv @@
// ----------------------------------------------------------------------------
// nnact_if
// Valid/ready stream interfaces for input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnact_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  logic               last_in;
  modport source (output valid, sample_in, last_in, input ready);
  modport sink   (input valid, sample_in, last_in, output ready);
endinterface

interface nnact_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               last_out;
  logic               status;
  modport source (output valid, sample_out, last_out, status, input ready);
  modport sink   (input valid, sample_out, last_out, status, output ready);
endinterface

`default_nettype wire

@@ design/nn_activation_unit_core.sv @@
// ----------------------------------------------------------------------------
// nn_activation_unit_core
// Activation unit for signed Q8.8 samples: relu, relu6, hard sigmoid,
// hard swish, gelu and tanh, selected by the mode register.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the output is not stalled, set by the seven-stage pipeline
// a stalled output holds its word; earlier stages keep filling bubbles
// reset: synchronous active-low, clears valids and sets mode to pass-through
`default_nettype none
`include "nn_activation_unit_core_macros.svh"

module nn_activation_unit_core import nnact_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  nnact_in_if.sink        in_word,
  nnact_out_if.source     out_word,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata
);

  logic [2:0]  act_mode_r;

  logic        f_valid, f_ready;
  front_t      f_data;
  logic        p_valid, p_ready;
  poly_t       p_data;
  logic        t_valid, t_ready;
  tanh_t       t_data;

  logic        out_v_r;
  logic signed [15:0] sample_r;
  logic        last_r;
  logic        status_r;
  logic        out_adv;

  logic [16:0] k;
  logic [32:0] g;
  logic [16:0] gm;
  logic [8:0]  tm;
  logic signed [17:0] r;
  logic signed [15:0] sample_nxt;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_mode_r <= MODE_NONE;
    end else if (cfg_we) begin
      act_mode_r <= cfg_wdata;
    end
  end

  nnact_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .mode    (act_mode_r),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_data  (f_data)
  );

  nnact_poly u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_data  (f_data),
    .p_valid (p_valid),
    .p_ready (p_ready),
    .p_data  (p_data)
  );

  nnact_tanh u_tanh (
    .clk     (clk),
    .rst_n   (rst_n),
    .p_valid (p_valid),
    .p_ready (p_ready),
    .p_data  (p_data),
    .t_valid (t_valid),
    .t_ready (t_ready),
    .t_data  (t_data)
  );

  // stage 7: gelu scaling, tanh rounding, final select and saturation
  assign out_adv = !out_v_r || out_word.ready;
  assign t_ready = out_adv;

  assign k  = t_data.b.neg ? (17'd32768 - 17'(t_data.t)) : (17'd32768 + 17'(t_data.t));
  assign g  = 33'(t_data.b.m) * 33'(k);
  assign gm = 17'((34'(g) + 34'd32768) >> 16);
  assign tm = 9'((17'(t_data.t) + 17'd64) >> 7);

  always_comb begin
    unique case (t_data.b.mode)
      MODE_GELU: r = t_data.b.neg ? -$signed({1'b0, gm}) : $signed({1'b0, gm});
      MODE_TANH: r = t_data.b.neg ? -$signed({9'd0, tm}) : $signed({9'd0, tm});
      default:   r = 18'(t_data.simple);
    endcase
    if (r > 18'sd32767) begin
      sample_nxt = 16'sh7fff;
    end else if (r < -18'sd32768) begin
      sample_nxt = 16'sh8000;
    end else begin
      sample_nxt = r[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= t_valid;
    end
    if (out_adv && t_valid) begin
      sample_r <= sample_nxt;
      last_r   <= t_data.b.last;
      status_r <= (t_data.b.mode == MODE_UNSUP);
    end
  end

  assign out_word.valid      = out_v_r;
  assign out_word.sample_out = sample_r;
  assign out_word.last_out   = last_r;
  assign out_word.status     = status_r;

  // checks
  `NNACT_CHK_IMP(a_stall_from_out, !in_word.ready, out_v_r && !out_word.ready, "input stalled without output backpressure")
  `NNACT_CHK_IMP(a_tanh_range, t_valid, t_data.t <= 16'h8000, "tanh magnitude above one")
  `NNACT_CHK_NXT(a_out_load, t_valid && out_adv, out_v_r, "result word lost at output stage")

endmodule

`default_nettype wire

@@ design/nnact_front.sv @@
// ----------------------------------------------------------------------------
// nnact_front
// Stages 1-2: magnitude, clamp, products, simple activations, cubic term.
// ----------------------------------------------------------------------------
`default_nettype none

module nnact_front import nnact_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nnact_in_if.sink    in_word,
  input  wire logic [2:0] mode,
  output logic        f_valid,
  input  wire logic   f_ready,
  output front_t      f_data
);

  logic        s1_v_r, s2_v_r;
  logic        adv1, adv2;
  base_t       s1_b_r;
  logic [23:0] s1_m2_r;
  logic [31:0] s1_c1m_r;
  logic [26:0] s1_sw_r;
  logic [10:0] s1_c_r;
  front_t      s2_r;

  logic signed [15:0] x;
  logic [15:0]        m_nxt;
  logic [11:0]        m12;
  logic signed [16:0] xs;
  logic [10:0]        c_nxt;
  base_t              b_nxt;

  logic [9:0]         ysig;
  logic [27:0]        psig;
  logic [17:0]        ysw;
  logic [35:0]        psw;
  logic [15:0]        qsw;
  logic signed [16:0] x17;
  logic signed [16:0] simple_nxt;
  front_t             s2_nxt;

  // stall chain
  assign adv2          = !s2_v_r || f_ready;
  assign adv1          = !s1_v_r || adv2;
  assign in_word.ready = adv1;

  // stage 1 inputs
  assign x     = in_word.sample_in;
  assign m_nxt = x[15] ? 16'(-x) : 16'(x);
  assign m12   = m_nxt[11:0];
  assign xs    = {x[15], x} + 17'sd768;

  always_comb begin
    if (xs < 0) begin
      c_nxt = '0;
    end else if (xs > 17'sd1536) begin
      c_nxt = 11'd1536;
    end else begin
      c_nxt = xs[10:0];
    end
    b_nxt.x    = x;
    b_nxt.m    = m_nxt;
    b_nxt.neg  = x[15];
    b_nxt.mode = mode;
    b_nxt.last = in_word.last_in;
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_word.valid;
    end
    if (adv1 && in_word.valid) begin
      s1_b_r   <= b_nxt;
      s1_m2_r  <= 24'(m12) * 24'(m12);
      s1_c1m_r <= 32'(C1_Q24) * 32'(m12);
      s1_sw_r  <= 27'(m_nxt) * 27'(c_nxt);
      s1_c_r   <= c_nxt;
    end
  end

  // stage 2: divide by six and by 1536 through a reciprocal of three
  assign ysig = 10'((12'(s1_c_r) + 12'd3) >> 1);
  assign psig = 28'(ysig) * 28'(RECIP3);
  assign ysw  = 18'((28'(s1_sw_r) + 28'd768) >> 9);
  assign psw  = 36'(ysw) * 36'(RECIP3);
  assign qsw  = 16'(psw >> 19);
  assign x17  = {s1_b_r.x[15], s1_b_r.x};

  always_comb begin
    unique case (s1_b_r.mode)
      MODE_NONE, MODE_UNSUP: simple_nxt = x17;
      MODE_RELU:   simple_nxt = s1_b_r.neg ? '0 : x17;
      MODE_RELU6: begin
        if (s1_b_r.neg) begin
          simple_nxt = '0;
        end else if (x17 > 17'sd1536) begin
          simple_nxt = 17'sd1536;
        end else begin
          simple_nxt = x17;
        end
      end
      MODE_HSIG:   simple_nxt = {8'd0, psig[27:19]};
      MODE_HSWISH: simple_nxt = s1_b_r.neg ? -$signed({1'b0, qsw}) : $signed({1'b0, qsw});
      default:     simple_nxt = '0;
    endcase
    s2_nxt.b      = s1_b_r;
    s2_nxt.m3c    = 56'(s1_c1m_r) * 56'(s1_m2_r);
    s2_nxt.simple = simple_nxt;
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
    if (adv2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign f_valid = s2_v_r;
  assign f_data  = s2_r;

endmodule

`default_nettype wire

@@ design/nnact_poly.sv @@
// ----------------------------------------------------------------------------
// nnact_poly
// Stages 3-4: gelu inner polynomial, scale to tanh argument.
// ----------------------------------------------------------------------------
`default_nettype none

module nnact_poly import nnact_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  f_valid,
  output logic       f_ready,
  input  front_t     f_data,
  output logic       p_valid,
  input  wire logic  p_ready,
  output poly_t      p_data
);

  logic        s3_v_r, s4_v_r;
  logic        adv3, adv4;
  base_t       s3_b_r;
  logic [33:0] s3_inner_r;
  logic        s3_gbig_r;
  logic signed [16:0] s3_simple_r;
  poly_t       s4_r;

  logic [33:0] inner_nxt;
  logic [57:0] zf;
  logic [26:0] z;
  logic [26:0] a;
  poly_t       s4_nxt;

  // stall chain
  assign adv4    = !s4_v_r || p_ready;
  assign adv3    = !s3_v_r || adv4;
  assign f_ready = adv3;

  // inner = m + 0.044715 m^3, Q24
  assign inner_nxt = 34'({f_data.b.m[11:0], 16'd0}) +
                     34'((57'(f_data.m3c) + 57'd8388608) >> 24);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv3) begin
      s3_v_r <= f_valid;
    end
    if (adv3 && f_valid) begin
      s3_b_r      <= f_data.b;
      s3_inner_r  <= inner_nxt;
      s3_gbig_r   <= |f_data.b.m[15:12];
      s3_simple_r <= f_data.simple;
    end
  end

  // z = sqrt(2/pi) * inner, Q16; tanh mode takes |x| directly
  assign zf = 58'(K0_Q24) * 58'(s3_inner_r);
  assign z  = 27'((59'(zf) + 59'd2147483648) >> 32);

  always_comb begin
    a             = (s3_b_r.mode == MODE_TANH) ? 27'({s3_b_r.m, 8'd0}) : z;
    s4_nxt.b      = s3_b_r;
    s4_nxt.targ   = a[17:0];
    s4_nxt.tbig   = (s3_b_r.mode == MODE_GELU && s3_gbig_r) || (|a[26:18]);
    s4_nxt.simple = s3_simple_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv4) begin
      s4_v_r <= s3_v_r;
    end
    if (adv4 && s3_v_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign p_valid = s4_v_r;
  assign p_data  = s4_r;

endmodule

`default_nettype wire

@@ design/nnact_tanh.sv @@
// ----------------------------------------------------------------------------
// nnact_tanh
// Stages 5-6: table lookup and linear interpolation of tanh.
// ----------------------------------------------------------------------------
`default_nettype none

module nnact_tanh import nnact_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  p_valid,
  output logic       p_ready,
  input  poly_t      p_data,
  output logic       t_valid,
  input  wire logic  t_ready,
  output tanh_t      t_data
);

  logic               s5_v_r, s6_v_r;
  logic               adv5, adv6;
  base_t              s5_b_r;
  logic [15:0]        s5_r0_r;
  logic [15:0]        s5_d_r;
  logic [TANH_FB-1:0] s5_f_r;
  logic               s5_tbig_r;
  logic signed [16:0] s5_simple_r;
  tanh_t              s6_r;

  logic [TANH_PW-1:0] p;
  logic [TANH_IW:0]   idx;
  logic [15:0]        r0, r1;
  logic [34:0]        sum;
  tanh_t              s6_nxt;

  // stall chain
  assign adv6    = !s6_v_r || t_ready;
  assign adv5    = !s5_v_r || adv6;
  assign p_ready = adv5;

  // split argument into table index and fraction
  assign p   = TANH_PW'(p_data.targ) * TANH_PW'(TANH_ENTRIES);
  assign idx = {1'b0, p[TANH_PW-1:TANH_FB]};
  assign r0  = TANH_ROM[idx];
  assign r1  = TANH_ROM[idx + 1'b1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv5) begin
      s5_v_r <= p_valid;
    end
    if (adv5 && p_valid) begin
      s5_b_r      <= p_data.b;
      s5_r0_r     <= r0;
      s5_d_r      <= r1 - r0;
      s5_f_r      <= p[TANH_FB-1:0];
      s5_tbig_r   <= p_data.tbig;
      s5_simple_r <= p_data.simple;
    end
  end

  // interpolate, round, saturate to one beyond the table
  assign sum = 35'({s5_r0_r, 18'd0}) + 35'(s5_d_r) * 35'(s5_f_r) + 35'd131072;

  always_comb begin
    s6_nxt.b      = s5_b_r;
    s6_nxt.t      = s5_tbig_r ? 16'h8000 : 16'(sum >> TANH_FB);
    s6_nxt.simple = s5_simple_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv6) begin
      s6_v_r <= s5_v_r;
    end
    if (adv6 && s5_v_r) begin
      s6_r <= s6_nxt;
    end
  end

  assign t_valid = s6_v_r;
  assign t_data  = s6_r;

endmodule

`default_nettype wire

@@ tb/nnact_checker.sv @@
// ----------------------------------------------------------------------------
// nnact_checker
// Watches the input, result and mode ports of the activation unit, predicts
// each result word from the accepted input word and the current mode, and
// compares the words in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module nnact_checker import nnact_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               in_last,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] out_sample,
  input  wire logic               out_last,
  input  wire logic               out_status,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_wdata,
  output int                      mismatches,
  output int                      pending,
  output int                      checked
);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               status;
  } act_word_t;

  act_word_t          expected_q[$];
  logic [2:0]         cur_mode;
  longint unsigned    tanh_table [0:TANH_ENTRIES];

  // tanh table in q15, from the exp series in q30
  initial begin
    longint unsigned e;
    longint unsigned term;
    longint unsigned num;
    longint unsigned den;
    for (int k = 0; k <= TANH_ENTRIES; k++) begin
      e    = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n <= 256 && term != 0; n++) begin
        term = term * (8 * k) / (TANH_ENTRIES * n);
        e    = e + term;
      end
      num = (e - (64'd1 << 30)) << 15;
      den = e + (64'd1 << 30);
      tanh_table[k] = (num + den / 2) / den;
    end
  end

  // tanh of a q16 magnitude, q15 out, interpolated between table points
  function automatic longint unsigned tanh_q15(longint unsigned a);
    longint unsigned p;
    longint unsigned i;
    longint unsigned f;
    if (a >= (64'd4 << 16)) return 32768;
    p = a * TANH_ENTRIES;
    i = p >> 18;
    f = p & ((64'd1 << 18) - 1);
    if (i >= TANH_ENTRIES) return tanh_table[TANH_ENTRIES];
    return (tanh_table[i] * ((64'd1 << 18) - f) + tanh_table[i + 1] * f
            + (64'd1 << 17)) >> 18;
  endfunction

  // one activated word for the given mode
  function automatic act_word_t activate(logic [2:0] mode, logic signed [15:0] s,
                                         logic l);
    act_word_t       w;
    longint          x;
    longint          r;
    longint          c;
    longint unsigned m;
    longint unsigned mag;
    longint unsigned t;
    longint unsigned inner;
    longint unsigned z;
    logic            neg;
    x   = s;
    neg = x < 0;
    m   = neg ? -x : x;
    w.status = 1'b0;
    case (mode)
      MODE_NONE:  r = x;
      MODE_RELU:  r = neg ? 0 : x;
      MODE_RELU6: r = neg ? 0 : (x > 1536 ? 1536 : x);
      MODE_HSIG, MODE_HSWISH: begin
        c = x + 768;
        if (c < 0) c = 0;
        if (c > 1536) c = 1536;
        if (mode == MODE_HSIG) begin
          r = (c + 3) / 6;
        end else begin
          mag = (m * longint'(c) + 768) / 1536;
          r   = neg ? -longint'(mag) : longint'(mag);
        end
      end
      MODE_GELU: begin
        // beyond 16.0 tanh is taken as exactly one
        if (m >= 4096) begin
          t = 32768;
        end else begin
          inner = (m << 16) + ((750193 * m * m * m + (64'd1 << 23)) >> 24);
          z     = (13386282 * inner + (64'd1 << 31)) >> 32;
          t     = tanh_q15(z);
        end
        if (neg) r = -longint'((m * (32768 - t) + 32768) >> 16);
        else     r = longint'((m * (32768 + t) + 32768) >> 16);
      end
      MODE_TANH: begin
        mag = (tanh_q15(m << 8) + 64) >> 7;
        r   = neg ? -longint'(mag) : longint'(mag);
      end
      default: begin
        r        = x;
        w.status = 1'b1;
      end
    endcase
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    w.sample = r[15:0];
    w.last   = l;
    return w;
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    $display("%0t: %s differs, expected %0d, got %0d", $realtime, field, want, got);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  // mode tracking, prediction and comparison
  always @(posedge clk) begin
    act_word_t want;
    if (!rst_n) begin
      cur_mode = MODE_NONE;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word, sample", 0, out_sample);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_sample !== want.sample) report_mismatch("sample", want.sample, out_sample);
          if (out_last !== want.last) report_mismatch("last", want.last, out_last);
          if (out_status !== want.status) report_mismatch("status", want.status, out_status);
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(activate(cur_mode, in_sample, in_last));
      if (cfg_we) cur_mode = cfg_wdata;
    end
    pending = expected_q.size();
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives the activation unit with directed and random words in every mode,
// with random idling on both sides, a long output stall and a drain pause,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb import nnact_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 20;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_wdata;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_asks;
  int         hold_seen;
  int         hold_left;
  int         quiet_cycles;
  int         mismatches;
  int         pending;
  int         checked;

  nnact_in_if  in_word();
  nnact_out_if out_word();

  nn_activation_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  nnact_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_word.valid),
    .in_ready   (in_word.ready),
    .in_sample  (in_word.sample_in),
    .in_last    (in_word.last_in),
    .out_valid  (out_word.valid),
    .out_ready  (out_word.ready),
    .out_sample (out_word.sample_out),
    .out_last   (out_word.last_out),
    .out_status (out_word.status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = MODE_NONE;
    in_word.valid      = 1'b0;
    in_word.sample_in  = '0;
    in_word.last_in    = 1'b0;
    out_word.ready     = 1'b0;
    tx_idle_pct        = 0;
    rx_idle_pct        = 0;
    hold_asks          = 0;
    hold_seen          = 0;
    hold_left          = 0;
    quiet_cycles       = 0;
  end

  always #1 clk = ~clk;

  // receiver: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_word.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      out_word.ready <= 1'b0;
      hold_seen      <= hold_asks;
      hold_left      <= HOLD_CYCLES;
    end else begin
      out_word.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one word, idling at random first, until it is taken
  task automatic send_word(logic signed [15:0] s, logic l);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid     <= 1'b1;
    in_word.sample_in <= s;
    in_word.last_in   <= l;
    do begin
      @(negedge clk);
      taken = in_word.valid && in_word.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // let the pipe empty, then write the mode
  task automatic set_mode(logic [2:0] mode);
    in_word.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(2400) - 1200);
      2:       return 16'($urandom_range(8800) - 4400);
      default: return 16'($urandom_range(300) - 150);
    endcase
  endfunction

  logic signed [15:0] dir_vals [0:2];

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and the edges of each mode's ranges
    for (int md = 0; md < 8; md++) begin
      set_mode(md[2:0]);
      case (md[2:0])
        MODE_NONE:   dir_vals = '{16'sh8000, 16'sd32767, 16'sd0};
        MODE_RELU:   dir_vals = '{-16'sd1, 16'sd1, 16'sd32767};
        MODE_RELU6:  dir_vals = '{16'sd1536, 16'sd1537, -16'sd5};
        MODE_HSIG:   dir_vals = '{-16'sd768, 16'sd768, 16'sd3};
        MODE_HSWISH: dir_vals = '{-16'sd769, 16'sd767, -16'sd300};
        MODE_GELU:   dir_vals = '{16'sd4096, -16'sd4096, 16'sd4095};
        MODE_TANH:   dir_vals = '{16'sd1024, -16'sd1023, 16'sh8000};
        default:     dir_vals = '{16'sh8000, 16'sd32767, -16'sd1};
      endcase
      for (int i = 0; i < 3; i++) send_word(dir_vals[i], i == 2);
    end

    // random: three idling phases, the mode is written anew every chunk
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 84 : 0;
      rx_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 28 : 0;
      for (int ch = 0; ch < 6; ch++) begin
        set_mode((ch < 2) ? ((ph + ch) % 2 ? MODE_UNSUP : MODE_NONE)
                          : 3'($urandom_range(7)));
        if (ph == 2 && ch == 1) hold_asks++;
        for (int i = 0; i < 47; i++) begin
          send_word(rand_sample(), $urandom_range(7) == 0);
          if (ph == 2 && ch == 3 && i == 20) begin
            in_word.valid <= 1'b0;
            @(posedge clk);
            wait (pending == 0);
          end
        end
      end
    end
    in_word.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d result words over all eight modes, with idling", checked);
    $display("and stalls on both sides, a long output hold and a drain pause");
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
